// ----- rtl/irpr_pkg.sv -----
// Shared types and constants for the oversampled IR packet receiver.
// No dependencies; used by the framer, the hold unit, the top level and the checker.
package irpr_pkg;

	localparam int unsigned PHASES_PER_BIT = 3;
	localparam int unsigned BITS_PER_BYTE  = 8;
	localparam int unsigned PACKET_BYTES   = 3;
	localparam int unsigned CODE_W         = 16;
	localparam int unsigned HOLD_W         = 16;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd200;
	// byte_slot value that means the packet is complete and the framer is idle
	localparam logic [1:0] SLOT_IDLE = 2'(PACKET_BYTES);

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [HOLD_W-1:0] hold_t;
	typedef logic [7:0]        byte_t;

	// latch event from the framer to the hold unit
	typedef struct packed {
		logic  fresh;
		code_t code;
	} latch_t;

	// one result beat
	typedef struct packed {
		code_t held_code;
		logic  code_fresh;
		logic  code_active;
	} result_t;

endpackage

// ----- rtl/ir_oversampled_packet_receiver.sv -----
// Top level of the oversampled IR packet receiver: framer, hold unit and result register.
// Depends on irpr_pkg, irpr_framer and irpr_hold.
//
// One receiver sample enters per beat and produces exactly one result beat in the next
// cycle, through a single result register. The block sustains one sample per cycle when
// not stalled: all state updates for a sample are done in one pass between the state
// registers and the result register. in_stall is high only while the result register
// holds a beat that the downstream side is stalling. Three samples form one bit (any low
// sample sets it), bits pack LSB first into three bytes, and after the third byte the
// code {byte2, byte1} is latched once and held for hold_ticks samples. hold_ticks resets
// to 200; the user writes it through cfg only while idle, which the block does not enforce.
module ir_oversampled_packet_receiver (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  rx_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output irpr_pkg::code_t       held_code,
	output logic                  code_fresh,
	output logic                  code_active,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  irpr_pkg::hold_t       cfg_data
);

	logic              step;
	logic              out_valid_q;
	irpr_pkg::latch_t  latch;
	irpr_pkg::result_t result;
	irpr_pkg::result_t result_q;

	assign in_stall  = out_valid_q & out_stall;
	assign step      = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	irpr_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rx_level (rx_level),
		.latch    (latch)
	);

	irpr_hold u_hold (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.latch     (latch),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!in_stall)
			out_valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (step)
			result_q <= result;
	end

	assign out_valid   = out_valid_q;
	assign held_code   = result_q.held_code;
	assign code_fresh  = result_q.code_fresh;
	assign code_active = result_q.code_active;

endmodule

// ----- rtl/irpr_framer.sv -----
// Bit and byte framing: sample phase, bit and byte counters, byte store, packet latch event.
// Depends on irpr_pkg.
module irpr_framer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            rx_level,
	output irpr_pkg::latch_t latch
);

	logic [1:0]            phase_q;
	logic [2:0]            bit_q;
	logic [1:0]            slot_q;
	logic                  pending_q;
	logic                  taken_q;
	irpr_pkg::byte_t       bytes_q [irpr_pkg::PACKET_BYTES];

	logic                  low;
	logic                  pend;
	logic                  idle;
	logic                  restart;
	logic                  do_latch;
	logic [2:0]            phase_sum;
	logic                  bit_wrap;
	logic [1:0]            phase_base;
	logic [2:0]            bit_base;
	logic [1:0]            slot_base;
	logic [1:0]            phase_d;
	logic [2:0]            bit_d;
	logic [1:0]            slot_d;
	logic                  pending_d;
	logic                  taken_d;
	irpr_pkg::byte_t       bytes_d [irpr_pkg::PACKET_BYTES];

	always_comb begin
		low      = ~rx_level;
		pend     = pending_q | low;
		idle     = (slot_q == irpr_pkg::SLOT_IDLE);
		do_latch = idle & ~taken_q;
		restart  = low & idle;

		for (int i = 0; i < int'(irpr_pkg::PACKET_BYTES); i++) begin
			if (do_latch)
				bytes_d[i] = '0;
			else if (!idle && slot_q == 2'(i))
				bytes_d[i] = bytes_q[i] | (8'(pend) << bit_q);
			else
				bytes_d[i] = bytes_q[i];
		end

		pending_d = idle ? pend : 1'b0;
		taken_d   = restart ? 1'b0 : (taken_q | do_latch);

		phase_base = restart ? '0 : phase_q;
		bit_base   = restart ? '0 : bit_q;
		slot_base  = restart ? '0 : slot_q;

		// a phase of 3 never occurs, but wraps like 2
		phase_sum = {1'b0, phase_base} + 3'd1;
		bit_wrap  = 1'b0;
		phase_d   = phase_sum[1:0];
		bit_d     = bit_base;
		slot_d    = slot_base;
		if (phase_sum >= 3'(irpr_pkg::PHASES_PER_BIT)) begin
			phase_d = '0;
			bit_d   = bit_base + 3'd1;
			bit_wrap = (bit_base == 3'(irpr_pkg::BITS_PER_BYTE - 1));
			if (bit_wrap && slot_base != irpr_pkg::SLOT_IDLE)
				slot_d = slot_base + 2'd1;
		end

		latch.fresh = step & do_latch;
		latch.code  = {bytes_q[2], bytes_q[1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			bit_q     <= '0;
			slot_q    <= '0;
			pending_q <= 1'b0;
			taken_q   <= 1'b0;
			for (int i = 0; i < int'(irpr_pkg::PACKET_BYTES); i++)
				bytes_q[i] <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			bit_q     <= bit_d;
			slot_q    <= slot_d;
			pending_q <= pending_d;
			taken_q   <= taken_d;
			for (int i = 0; i < int'(irpr_pkg::PACKET_BYTES); i++)
				bytes_q[i] <= bytes_d[i];
		end
	end

endmodule

// ----- rtl/irpr_hold.sv -----
// Hold countdown, held code register and the hold_ticks configuration register.
// Depends on irpr_pkg; fed by irpr_framer latch events.
module irpr_hold (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  irpr_pkg::latch_t  latch,
	input  logic              cfg_valid,
	input  irpr_pkg::hold_t   cfg_data,
	output irpr_pkg::result_t result
);

	irpr_pkg::hold_t hold_ticks_q;
	irpr_pkg::hold_t count_q;
	irpr_pkg::code_t code_q;
	irpr_pkg::hold_t count_dec;
	irpr_pkg::hold_t count_d;
	irpr_pkg::code_t code_d;

	always_comb begin
		count_dec = (count_q != '0) ? count_q - irpr_pkg::hold_t'(1) : count_q;
		code_d    = (count_dec == '0) ? '0 : code_q;
		count_d   = count_dec;
		if (latch.fresh) begin
			code_d  = latch.code;
			count_d = hold_ticks_q;
		end
		result.held_code   = code_d;
		result.code_fresh  = latch.fresh;
		result.code_active = (count_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= irpr_pkg::HOLD_RESET;
			count_q      <= '0;
			code_q       <= '0;
		end else begin
			if (cfg_valid)
				hold_ticks_q <= cfg_data;
			if (step) begin
				count_q <= count_d;
				code_q  <= code_d;
			end
		end
	end

endmodule

// ----- rtl/irpr_checker.sv -----
// Port-level checks for the oversampled IR packet receiver, bound to the top level.
// Depends on irpr_pkg and ir_oversampled_packet_receiver.
module irpr_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input irpr_pkg::code_t held_code,
	input logic            code_fresh,
	input logic            code_active
);

	// only a stalled pending result may hold off the input
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	// every input beat yields a result beat on the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("input beat produced no result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(held_code)
			&& $stable(code_fresh) && $stable(code_active)))
		else $error("stalled result changed");

	// outside the latch beat a nonzero code implies the countdown is running
	a_code_expired: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !code_fresh && !code_active) |-> (held_code == '0))
		else $error("code held after countdown expired");

endmodule

bind ir_oversampled_packet_receiver irpr_checker u_irpr_checker (.*);
